FILE: hw/rtl/clos_pkg.sv
package clos_pkg;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int HOP_W  = 8;
  localparam int PORT_W = 6;
  localparam int SP_W   = 7;
  localparam int HALF_W = SP_W - 1;
  localparam int LFSR_W = 16;
  localparam int HASH_W = 16;

  // Stream packing
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 40;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_PORTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOR_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRAY       = 2'd3;

  // Register reset values
  localparam logic [ADDR_W-1:0] NODE_ID_RST      = '0;
  localparam logic [SP_W-1:0]   SWITCH_PORTS_RST = 7'd6;
  localparam logic [SP_W-1:0]   TOR_COUNT_RST    = 7'd4;
  localparam logic              SPRAY_RST        = 1'b1;

  // LFSR seed
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = ADDR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Hop count ceiling
  localparam logic [HOP_W-1:0] HOP_MAX = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } clos_state_t;

  // Routing decision kept for the result stage
  typedef struct packed {
    logic deliver_local;
    logic hop_ge1;
    logic half_zero;
  } route_flags_t;

endpackage

FILE: hw/rtl/clos_div.sv
module clos_div
  import clos_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [HALF_W-1:0] divisor,
  output logic              busy,
  output logic              last,
  output logic [ADDR_W-1:0] quot,
  output logic [HALF_W-1:0] rem
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [HALF_W-1:0]    dvsr;
  logic [HALF_W:0]      trial;
  logic                 fits;

  // Shift next dividend bit into the partial remainder and trial-subtract
  assign trial = {rem, quot[ADDR_W-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign last  = busy && (cnt == DIV_LAST);

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= HALF_W'(trial - {1'b0, dvsr});
      end else begin
        rem <= trial[HALF_W-1:0];
      end
      quot <= {quot[ADDR_W-2:0], fits};
    end
  end

endmodule

FILE: hw/rtl/clos_hash.sv
module clos_hash
  import clos_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              spray,
  input  logic [ADDR_W-1:0] src_addr,
  input  logic [ADDR_W-1:0] dest_addr,
  input  logic [PORT_W-1:0] in_port,
  output logic [HASH_W-1:0] hash
);

  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] lfsr_next;
  logic [HASH_W-1:0] flow;

  // Fibonacci step, taps 16,14,13,11
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};

  // Fold address halves and ingress port
  assign flow = src_addr[15:0] ^ src_addr[31:16] ^ dest_addr[15:0] ^ dest_addr[31:16]
              ^ {{(HASH_W-PORT_W){1'b0}}, in_port};

  // Spray uses the advanced LFSR value
  assign hash = spray ? lfsr_next : flow;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_SEED;
    end else if (advance) begin
      lfsr <= lfsr_next;
    end
  end

endmodule

FILE: hw/rtl/clos_ecmp_port_select.sv
// A forwarded packet passes from its input beat through the decide state, 32 divider
// steps and the result state to its result beat; local delivery or a half port count
// of zero skips the shared bit-serial divider.
// One packet is in work at a time: input is held off until its result is loaded,
// and longer while an earlier result is held.
// Reset (rst, synchronous): registers to defaults, LFSR to 0xACE1, output empty.
module clos_ecmp_port_select
  import clos_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // src_addr[31:0], dest_addr[63:32],
                                           // hop_count[71:64], in_port[77:72], zero pad
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // out_port[31:0], hop_count_out[39:32]
  output logic                  m_tuser    // deliver_local
);

  // Configuration registers
  logic [ADDR_W-1:0] node_id;
  logic [SP_W-1:0]   switch_ports;
  logic [SP_W-1:0]   tor_count;
  logic              per_packet_spray;

  // Captured header
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dest_addr;
  logic [HOP_W-1:0]  hop_count;
  logic [PORT_W-1:0] in_port;

  clos_state_t  state;
  clos_state_t  state_next;
  route_flags_t flags;
  route_flags_t flags_next;

  logic [HALF_W-1:0]     half;
  logic [2*SP_W-1:0]     tor_prod;
  logic [2*SP_W-1:0]     lower;
  logic                  node_lower;
  logic [HASH_W-1:0]     hash;
  logic                  lfsr_adv;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_last;
  logic [ADDR_W-1:0]     div_dividend;
  logic [ADDR_W-1:0]     div_quot;
  logic [HALF_W-1:0]     div_rem;
  logic                  out_load;
  logic                  accept;
  logic [ADDR_W-1:0]     port_sel;
  logic [HOP_W-1:0]      hop_sel;

  assign accept = s_tvalid && s_tready;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id          <= NODE_ID_RST;
      switch_ports     <= SWITCH_PORTS_RST;
      tor_count        <= TOR_COUNT_RST;
      per_packet_spray <= SPRAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:      node_id          <= cfg_data[ADDR_W-1:0];
        CFG_SWITCH_PORTS: switch_ports     <= cfg_data[SP_W-1:0];
        CFG_TOR_COUNT:    tor_count        <= cfg_data[SP_W-1:0];
        CFG_SPRAY:        per_packet_spray <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture header beat
  always_ff @(posedge clk) begin
    if (accept) begin
      src_addr  <= s_tdata[31:0];
      dest_addr <= s_tdata[63:32];
      hop_count <= s_tdata[71:64];
      in_port   <= s_tdata[77:72];
    end
  end

  // Tier boundary: tor_count*switch_ports/2 + tor_count
  assign half       = switch_ports[SP_W-1:1];
  assign tor_prod   = {{SP_W{1'b0}}, tor_count} * {{SP_W{1'b0}}, switch_ports};
  assign lower      = (tor_prod >> 1) + {{SP_W{1'b0}}, tor_count};
  assign node_lower = node_id < {{(ADDR_W-2*SP_W){1'b0}}, lower};

  // Classify the packet in the decide cycle
  always_comb begin
    flags_next.deliver_local = dest_addr == node_id;
    flags_next.hop_ge1       = hop_count != '0;
    flags_next.half_zero     = half == '0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      flags <= flags_next;
    end
  end

  assign div_dividend = flags_next.hop_ge1 ? dest_addr : {{(ADDR_W-HASH_W){1'b0}}, hash};

  clos_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .advance   (lfsr_adv),
    .spray     (per_packet_spray),
    .src_addr  (src_addr),
    .dest_addr (dest_addr),
    .in_port   (in_port),
    .hash      (hash)
  );

  clos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (half),
    .busy     (div_busy),
    .last     (div_last),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (flags_next.deliver_local || flags_next.half_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    lfsr_adv  = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DECIDE: begin
        div_start = !flags_next.deliver_local && !flags_next.half_zero;
        lfsr_adv  = !flags_next.deliver_local && !flags_next.hop_ge1 && per_packet_spray;
      end
      ST_DIV: ;
      ST_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // Select egress port and next hop count
  always_comb begin
    if (flags.deliver_local || flags.half_zero) begin
      port_sel = '0;
    end else if (!flags.hop_ge1) begin
      port_sel = {{(ADDR_W-HALF_W-1){1'b0}}, {1'b0, div_rem} + {1'b0, half}};
    end else if (node_lower) begin
      port_sel = {{(ADDR_W-HALF_W){1'b0}}, div_rem};
    end else begin
      port_sel = div_quot;
    end
    if (flags.deliver_local) begin
      hop_sel = '0;
    end else if (hop_count == HOP_MAX) begin
      hop_sel = HOP_MAX;
    end else begin
      hop_sel = hop_count + 1'b1;
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {hop_sel, port_sel};
      m_tuser <= flags.deliver_local;
    end
  end

  // Local delivery carries zero port and zero hop count
  a_local_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("local delivery beat with nonzero payload");

  // A forwarded packet always leaves with a nonzero hop count
  a_fwd_hop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[M_DATA_W-1:ADDR_W] != '0)
    else $error("forwarded beat with zero hop count");

  // Divider runs only under the divide state
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV)
    else $error("divider busy outside divide state");

  // An accepted header is classified in the next cycle
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DECIDE)
    else $error("accepted header not followed by decide");

  // A pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("pending result lost");

endmodule

FILE: tb/sv/clos_ecmp_port_select_tb.sv
`timescale 1ns / 100ps

module clos_ecmp_port_select_tb;
  import clos_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_HEADERS  = 85;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;

  // Packet header as carried on the input stream, src_addr in the low bits
  typedef struct packed {
    logic [PORT_W-1:0] in_port;
    logic [HOP_W-1:0]  hops;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
  } header_t;

  // Forwarding decision for one header
  typedef struct packed {
    logic              deliver;
    logic [ADDR_W-1:0] port;
    logic [HOP_W-1:0]  hops;
  } choice_t;

  // Mirror of the fabric registers and the spray LFSR; queue of pending decisions
  class port_choice_board;
    logic [ADDR_W-1:0] node_id;
    logic [SP_W-1:0]   ports;
    logic [SP_W-1:0]   tors;
    logic              spray;
    logic [LFSR_W-1:0] lfsr;
    choice_t           awaited_choices[$];
    int                faults;
    int                reported;

    function new();
      node_id  = NODE_ID_RST;
      ports    = SWITCH_PORTS_RST;
      tors     = TOR_COUNT_RST;
      spray    = SPRAY_RST;
      lfsr     = LFSR_SEED;
      faults   = 0;
      reported = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_NODE_ID:      node_id = val[ADDR_W-1:0];
        CFG_SWITCH_PORTS: ports   = val[SP_W-1:0];
        CFG_TOR_COUNT:    tors    = val[SP_W-1:0];
        CFG_SPRAY:        spray   = val[0];
        default: ;
      endcase
    endfunction

    // Work out the egress decision for an accepted header
    function void take_header(header_t h);
      choice_t           c;
      logic [ADDR_W-1:0] half;
      logic [ADDR_W-1:0] lower;
      logic [HASH_W-1:0] hash;
      c     = '0;
      half  = 32'(ports) >> 1;
      lower = (32'(tors) * 32'(ports)) / 32'd2 + 32'(tors);
      if (h.dest == node_id) begin
        c.deliver = 1'b1;
      end else begin
        if (h.hops != '0) begin
          // downward: lower tiers take dest mod half, upper tiers dest / half
          if (half != 0)
            c.port = (node_id < lower) ? h.dest % half : h.dest / half;
        end else begin
          // upward: spray LFSR or flow fold picks the uplink
          if (spray) begin
            lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
            hash = lfsr;
          end else begin
            hash = h.src[15:0] ^ h.src[31:16] ^ h.dest[15:0] ^ h.dest[31:16]
                 ^ HASH_W'(h.in_port);
          end
          if (half != 0)
            c.port = 32'(hash) % half + half;
        end
        c.hops = (h.hops == HOP_MAX) ? HOP_MAX : h.hops + 1'b1;
      end
      awaited_choices.push_back(c);
    endfunction

    // Compare a result beat with the oldest pending decision
    function void check_choice(logic user, logic [M_DATA_W-1:0] data);
      choice_t got;
      choice_t want;
      got.deliver = user;
      got.port    = data[ADDR_W-1:0];
      got.hops    = data[ADDR_W+HOP_W-1:ADDR_W];
      if (awaited_choices.size() == 0) begin
        faults++;
        if (reported < REPORT_LIMIT)
          $display("unexpected result beat: local=%0d port=%0d hops=%0d",
                   got.deliver, got.port, got.hops);
        reported++;
        return;
      end
      want = awaited_choices.pop_front();
      if (got.deliver !== want.deliver || got.port !== want.port ||
          got.hops !== want.hops) begin
        faults++;
        if (reported < REPORT_LIMIT)
          $display("mismatch: exp local=%0d port=%0d hops=%0d, got local=%0d port=%0d hops=%0d",
                   want.deliver, want.port, want.hops, got.deliver, got.port, got.hops);
        reported++;
      end
    endfunction

    function int outstanding();
      return awaited_choices.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;   // src_addr, dest_addr, hop_count, in_port, zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;   // out_port, hop_count_out
  logic                  m_tuser;   // deliver_local

  port_choice_board board;
  bit               calm;
  bit               hold_req;
  int               hold_left;
  int               cycle_count;
  logic [ADDR_W-1:0] fabric_node;

  clos_ecmp_port_select dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("clos_ecmp_port_select verification failed");
      $finish;
    end
  end

  // Result side: random stalls, calm stretches, one long hold-off on request
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_choice(m_tuser, m_tdata);
  end

  function automatic header_t hdr(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dest,
                                  logic [HOP_W-1:0] hops, logic [PORT_W-1:0] in_port);
    header_t h;
    h.src     = src;
    h.dest    = dest;
    h.hops    = hops;
    h.in_port = in_port;
    return h;
  endfunction

  // Random header weighted toward local hits, first hops and saturation
  function automatic header_t random_header();
    header_t h;
    int      r;
    int      q;
    r         = $urandom_range(99);
    q         = $urandom_range(99);
    h.src     = $urandom;
    h.dest    = (r < 12) ? fabric_node : (r < 30) ? ADDR_W'($urandom_range(0, 300)) : $urandom;
    h.hops    = (q < 40) ? '0 : (q < 46) ? HOP_MAX : (q < 70) ? HOP_W'(1)
                                         : HOP_W'($urandom_range(0, 255));
    h.in_port = PORT_W'($urandom_range(0, 63));
    return h;
  endfunction

  // Offer one header beat, with an occasional gap ahead of it
  task automatic offer_header(input header_t h);
    if (!calm && $urandom_range(99) < 28) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(h);
    do @(posedge clk); while (!s_tready);
    board.take_header(h);
  endtask

  // Stop offering and wait until every pending decision has come back
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.set_reg(idx, val);
  endtask

  // Drain, then program all four fabric registers
  task automatic set_fabric(input logic [CFG_DATA_W-1:0] node, input logic [CFG_DATA_W-1:0] sp,
                            input logic [CFG_DATA_W-1:0] tor, input logic [CFG_DATA_W-1:0] spr);
    settle();
    write_reg(CFG_NODE_ID, node);
    write_reg(CFG_SWITCH_PORTS, sp);
    write_reg(CFG_TOR_COUNT, tor);
    write_reg(CFG_SPRAY, spr);
    @(negedge clk);
    cfg_we <= 1'b0;
    fabric_node = node;
  endtask

  initial begin
    int          ph;
    int          n;
    logic [6:0]  sp;
    logic [6:0]  tor;
    logic [31:0] lower;
    logic [31:0] node;

    board       = new();
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CFG_NODE_ID;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    cycle_count = 0;
    fabric_node = NODE_ID_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: local hit, spray uplinks, lower-tier downlink, hop saturation
    offer_header(hdr(32'h0000_0001, 32'h0, 8'd7, 6'd0));
    offer_header(hdr(32'h0, 32'h1, 8'd0, 6'd0));
    offer_header(hdr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 6'd63));
    offer_header(hdr(32'h0, 32'hFFFF_FFFF, 8'd1, 6'd5));
    offer_header(hdr(32'h8000_0000, 32'd100, 8'd255, 6'd1));
    offer_header(hdr(32'h5555_5555, 32'd7, 8'd254, 6'd62));
    offer_header(hdr(32'hFFFF_FFFF, 32'h0, 8'd255, 6'd63));

    // Flow hash uplinks
    set_fabric(32'h0, 32'd6, 32'd4, 32'd0);
    offer_header(hdr(32'h1234_5678, 32'h9ABC_DEF0, 8'd0, 6'h2A));
    offer_header(hdr(32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'd0, 6'd63));
    offer_header(hdr(32'h0, 32'h1, 8'd0, 6'd0));

    // Widest fabric, top-tier node: divide on the way down
    set_fabric(32'hFFFF_FFFF, 32'd64, 32'd64, 32'd0);
    offer_header(hdr(32'h0, 32'hFFFF_FFFF, 8'd0, 6'd0));
    offer_header(hdr(32'h0F0F_0F0F, 32'hFFFF_FFFE, 8'd1, 6'd21));
    offer_header(hdr(32'hFFFF_0000, 32'h0, 8'd0, 6'd63));
    offer_header(hdr(32'h0000_FFFF, 32'd12345, 8'd200, 6'd42));

    // Half port count zero: port stays 0, LFSR still steps on first hops
    set_fabric(32'd5, 32'd1, 32'd1, 32'd1);
    offer_header(hdr(32'h0, 32'd6, 8'd0, 6'd3));
    offer_header(hdr(32'h0, 32'd0, 8'd3, 6'd3));
    offer_header(hdr(32'h0, 32'd5, 8'd0, 6'd3));
    set_fabric(32'd5, 32'd0, 32'd1, 32'd1);
    offer_header(hdr(32'hA5A5_A5A5, 32'd9, 8'd0, 6'd10));
    offer_header(hdr(32'h5A5A_5A5A, 32'd9, 8'd255, 6'd10));

    // Tier boundary: lower limit is 2 with two ports and one rack switch
    set_fabric(32'd1, 32'd2, 32'd1, 32'd0);
    offer_header(hdr(32'h0, 32'd77, 8'd1, 6'd0));
    set_fabric(32'd2, 32'd2, 32'd1, 32'd0);
    offer_header(hdr(32'h0, 32'd77, 8'd1, 6'd0));
    offer_header(hdr(32'h0, 32'hFFFF_FFFF, 8'd9, 6'd0));

    // Random phases over a spread of fabric settings, junk in unused data bits
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: sp = 7'd2;
        1: sp = 7'd64;
        2: sp = 7'd0;
        3: sp = 7'd3;
        4: sp = 7'd127;
        5: sp = 7'd1;
        default: sp = 7'($urandom_range(2, 64));
      endcase
      case (ph % 4)
        0: tor = 7'd1;
        1: tor = 7'd64;
        2: tor = 7'd127;
        default: tor = 7'($urandom_range(1, 64));
      endcase
      lower = (32'(tor) * 32'(sp)) / 32'd2 + 32'(tor);
      case (ph % 3)
        0: node = $urandom_range(0, 2 * lower);
        1: node = $urandom;
        default: node = lower - 32'(ph % 2);
      endcase
      set_fabric(node, ($urandom & ~32'h7F) | 32'(sp), ($urandom & ~32'h7F) | 32'(tor),
                 ($urandom & ~32'h1) | 32'(ph % 2));
      @(posedge clk);
      calm = (ph == 3);
      if (ph == 5)
        hold_req = 1'b1;
      for (n = 0; n < PHASE_HEADERS; n++)
        offer_header(random_header());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.faults == 0 && board.outstanding() == 0) begin
      $display("clos_ecmp_port_select verification clean");
    end else begin
      $display("clos_ecmp_port_select verification failed");
    end
    $finish;
  end

endmodule
